[sv/stmac_pkg.sv]
// ----------------------------------------------------------------------------
// stmac_pkg
// Shared types and constants for the slot table: field widths, op codes,
// datapath step codes and the command/status words between control and data.
// ----------------------------------------------------------------------------
package stmac_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int OP_W      = 3;
    localparam int KEY_W     = 16;
    localparam int AMT_W     = 16;
    localparam int CNT_W     = 32;
    localparam int SLOT_W    = 8;

    typedef logic [OP_W-1:0] op_code_t;

    localparam op_code_t OP_ADD     = 3'd0;
    localparam op_code_t OP_REMOVE  = 3'd1;
    localparam op_code_t OP_SWAP    = 3'd2;
    localparam op_code_t OP_COMPACT = 3'd3;
    localparam op_code_t OP_READ    = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_REMOVE,
        STEP_SCAN,
        STEP_ADD_WR,
        STEP_RD_ISSUE,
        STEP_RD_DONE,
        STEP_SWAP_RDA,
        STEP_SWAP_RDB,
        STEP_SWAP_WRA,
        STEP_SWAP_WRB,
        STEP_CMP,
        STEP_RESP
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        op_code_t op;
        logic     a_ok;
        logic     b_ok;
        logic     scan_last;
        logic     out_free;
    } stat_t;

endpackage

[sv/slot_table_merge_alloc_compact.sv]
// ----------------------------------------------------------------------------
// slot_table_merge_alloc_compact
// Slot table with merge-on-add, lowest-empty allocation, remove, swap,
// stable compaction and slot read.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | op, item_key, add_count, slot_a, slot_b
//  out     | out_valid / out_ready| ok, slot_used, slot_item_key,
//          |                      | slot_item_count
//
//  Add and compact walk the table through the single memory read port, one
//  slot a cycle. out_valid rises as the sequencer leaves its response state
//  for every op, refused ops included, and in_ready rises with it, so a new
//  word is taken only once the last one has been handed off.
//  Reset clears all valid flags at once; no clearing pass is needed.
//  One word is in work at a time; the output register holds a finished word
//  while the next input word is accepted, and a stalled output holds the
//  sequencer only at its final hand-off.
// ----------------------------------------------------------------------------
module slot_table_merge_alloc_compact
#(
    parameter int SLOTS = stmac_pkg::SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [stmac_pkg::OP_W-1:0]     op,
    input  logic [stmac_pkg::KEY_W-1:0]    item_key,
    input  logic [stmac_pkg::AMT_W-1:0]    add_count,
    input  logic [stmac_pkg::SLOT_W-1:0]   slot_a,
    input  logic [stmac_pkg::SLOT_W-1:0]   slot_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic                           slot_used,
    output logic [stmac_pkg::KEY_W-1:0]    slot_item_key,
    output logic [stmac_pkg::CNT_W-1:0]    slot_item_count
);

    stmac_pkg::cmd_t  cmd;
    stmac_pkg::stat_t stat;

    stmac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stmac_dp
    #(
        .SLOTS (SLOTS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .item_key        (item_key),
        .add_count       (add_count),
        .slot_a          (slot_a),
        .slot_b          (slot_b),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .slot_used       (slot_used),
        .slot_item_key   (slot_item_key),
        .slot_item_count (slot_item_count)
    );

endmodule

[sv/stmac_ctrl.sv]
// ----------------------------------------------------------------------------
// stmac_ctrl
// Sequencer for the slot table: decodes one op at a time and steps the
// datapath through scans, swaps and compaction, then hands off the result.
// ----------------------------------------------------------------------------
module stmac_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  stmac_pkg::stat_t stat,
    output stmac_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_SCAN     = 12'b0000_0000_0100,
        S_SCAN_END = 12'b0000_0000_1000,
        S_ADD_WR   = 12'b0000_0001_0000,
        S_RD_WAIT  = 12'b0000_0010_0000,
        S_SWAP_B   = 12'b0000_0100_0000,
        S_SWAP_W1  = 12'b0000_1000_0000,
        S_SWAP_W2  = 12'b0001_0000_0000,
        S_CMP      = 12'b0010_0000_0000,
        S_CMP_END  = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = stmac_pkg::STEP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    stmac_pkg::OP_ADD:
                    begin
                        state_next = S_SCAN;
                    end
                    stmac_pkg::OP_REMOVE:
                    begin
                        if (stat.a_ok)
                        begin
                            cmd.step = stmac_pkg::STEP_REMOVE;
                        end
                        state_next = S_RESP;
                    end
                    stmac_pkg::OP_SWAP:
                    begin
                        if (stat.a_ok && stat.b_ok)
                        begin
                            cmd.step   = stmac_pkg::STEP_SWAP_RDA;
                            state_next = S_SWAP_B;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    stmac_pkg::OP_COMPACT:
                    begin
                        state_next = S_CMP;
                    end
                    stmac_pkg::OP_READ:
                    begin
                        if (stat.a_ok)
                        begin
                            cmd.step   = stmac_pkg::STEP_RD_ISSUE;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        // unknown op: answer with ok low
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.step = stmac_pkg::STEP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // let the last read land in the match logic
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.step   = stmac_pkg::STEP_ADD_WR;
                state_next = S_RESP;
            end
            S_RD_WAIT:
            begin
                cmd.step   = stmac_pkg::STEP_RD_DONE;
                state_next = S_RESP;
            end
            S_SWAP_B:
            begin
                cmd.step   = stmac_pkg::STEP_SWAP_RDB;
                state_next = S_SWAP_W1;
            end
            S_SWAP_W1:
            begin
                cmd.step   = stmac_pkg::STEP_SWAP_WRA;
                state_next = S_SWAP_W2;
            end
            S_SWAP_W2:
            begin
                cmd.step   = stmac_pkg::STEP_SWAP_WRB;
                state_next = S_RESP;
            end
            S_CMP:
            begin
                cmd.step = stmac_pkg::STEP_CMP;
                if (stat.scan_last)
                begin
                    state_next = S_CMP_END;
                end
            end
            S_CMP_END:
            begin
                // pending move is written here
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.step   = stmac_pkg::STEP_RESP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/stmac_dp.sv]
// ----------------------------------------------------------------------------
// stmac_dp
// Slot table datapath: valid flags, key/count memory with registered read,
// scan and compaction pointers, result and output registers.
// ----------------------------------------------------------------------------
module stmac_dp
#(
    parameter int SLOTS = stmac_pkg::SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stmac_pkg::cmd_t                cmd,
    output stmac_pkg::stat_t               stat,
    input  logic [stmac_pkg::OP_W-1:0]     op,
    input  logic [stmac_pkg::KEY_W-1:0]    item_key,
    input  logic [stmac_pkg::AMT_W-1:0]    add_count,
    input  logic [stmac_pkg::SLOT_W-1:0]   slot_a,
    input  logic [stmac_pkg::SLOT_W-1:0]   slot_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic                           slot_used,
    output logic [stmac_pkg::KEY_W-1:0]    slot_item_key,
    output logic [stmac_pkg::CNT_W-1:0]    slot_item_count
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = stmac_pkg::SLOT_W;
    localparam int CW = stmac_pkg::CNT_W;
    localparam int KW = stmac_pkg::KEY_W;
    localparam int AW = stmac_pkg::AMT_W;
    localparam logic [SW:0]   SLOTS_LIM = (SW+1)'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

    // captured item
    logic [stmac_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]              key_reg;
    logic [AW-1:0]              amt_reg;
    logic [SW-1:0]              a_reg;
    logic [SW-1:0]              b_reg;

    // table
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  valid_next;
    stmac_pkg::entry_t mem [SLOTS];
    stmac_pkg::entry_t rd_data_reg;
    stmac_pkg::entry_t hold_reg;

    // scan / compact state
    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  wptr_reg;
    logic           pend_reg;
    logic [IW-1:0]  pend_idx_reg;
    logic           hit_reg;
    logic [IW-1:0]  hit_idx_reg;
    logic [CW-1:0]  hit_cnt_reg;
    logic           empty_reg;
    logic [IW-1:0]  empty_idx_reg;
    logic           mv_pend_reg;
    logic [IW-1:0]  mv_dst_reg;

    // result and output
    logic           res_ok_reg;
    logic           res_used_reg;
    logic [KW-1:0]  res_key_reg;
    logic [CW-1:0]  res_cnt_reg;
    logic           out_valid_reg;
    logic           ok_reg;
    logic           used_reg;
    logic [KW-1:0]  okey_reg;
    logic [CW-1:0]  ocnt_reg;

    logic [IW-1:0]     a_idx;
    logic [IW-1:0]     b_idx;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    stmac_pkg::entry_t wr_data;
    logic [CW:0]       sum_wide;
    logic [CW-1:0]     sum_sat;
    logic              match;
    logic              cmp_move;
    logic              out_free;

    assign a_idx    = a_reg[IW-1:0];
    assign b_idx    = b_reg[IW-1:0];
    assign sum_wide = {1'b0, hit_cnt_reg} + (CW+1)'(amt_reg);
    assign sum_sat  = sum_wide[CW] ? {CW{1'b1}} : sum_wide[CW-1:0];
    assign match    = pend_reg && valid_reg[pend_idx_reg] && (rd_data_reg.key == key_reg);
    assign cmp_move = (cmd.step == stmac_pkg::STEP_CMP) && valid_reg[idx_reg]
                      && (idx_reg != wptr_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.op        = op_reg;
    assign stat.a_ok      = {1'b0, a_reg} < SLOTS_LIM;
    assign stat.b_ok      = {1'b0, b_reg} < SLOTS_LIM;
    assign stat.scan_last = idx_reg == LAST_IDX;
    assign stat.out_free  = out_free;

    // memory read port
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (cmd.step)
            stmac_pkg::STEP_SCAN, stmac_pkg::STEP_CMP:
            begin
                rd_en = 1'b1;
            end
            stmac_pkg::STEP_RD_ISSUE, stmac_pkg::STEP_SWAP_RDA:
            begin
                rd_en   = 1'b1;
                rd_addr = a_idx;
            end
            stmac_pkg::STEP_SWAP_RDB:
            begin
                rd_en   = 1'b1;
                rd_addr = b_idx;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = mv_dst_reg;
        wr_data = rd_data_reg;
        if (mv_pend_reg)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            case (cmd.step)
                stmac_pkg::STEP_ADD_WR:
                begin
                    wr_data.key = key_reg;
                    if (hit_reg)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = hit_idx_reg;
                        wr_data.count = sum_sat;
                    end
                    else
                    begin
                        wr_en         = empty_reg;
                        wr_addr       = empty_idx_reg;
                        wr_data.count = CW'(amt_reg);
                    end
                end
                stmac_pkg::STEP_SWAP_WRA:
                begin
                    wr_en   = 1'b1;
                    wr_addr = a_idx;
                end
                stmac_pkg::STEP_SWAP_WRB:
                begin
                    wr_en   = 1'b1;
                    wr_addr = b_idx;
                    wr_data = hold_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        case (cmd.step)
            stmac_pkg::STEP_REMOVE:
            begin
                valid_next[a_idx] = 1'b0;
            end
            stmac_pkg::STEP_ADD_WR:
            begin
                if (!hit_reg && empty_reg)
                begin
                    valid_next[empty_idx_reg] = 1'b1;
                end
            end
            stmac_pkg::STEP_SWAP_WRA:
            begin
                valid_next[a_idx] = valid_reg[b_idx];
                valid_next[b_idx] = valid_reg[a_idx];
            end
            stmac_pkg::STEP_CMP:
            begin
                if (cmp_move)
                begin
                    valid_next[wptr_reg] = 1'b1;
                    valid_next[idx_reg]  = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            wptr_reg      <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pend_reg    <= cmd.step == stmac_pkg::STEP_SCAN;
            mv_pend_reg <= cmp_move;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                wptr_reg  <= '0;
                hit_reg   <= 1'b0;
                empty_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step == stmac_pkg::STEP_SCAN || cmd.step == stmac_pkg::STEP_CMP)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.step == stmac_pkg::STEP_CMP && valid_reg[idx_reg])
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                // lowest empty slot, noted as the scan passes it
                if (cmd.step == stmac_pkg::STEP_SCAN && !valid_reg[idx_reg])
                begin
                    empty_reg <= 1'b1;
                end
            end
            if (cmd.step == stmac_pkg::STEP_RESP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= idx_reg;
        mv_dst_reg   <= wptr_reg;
        if (cmd.load)
        begin
            op_reg       <= op;
            key_reg      <= item_key;
            amt_reg      <= add_count;
            a_reg        <= slot_a;
            b_reg        <= slot_b;
            res_ok_reg   <= 1'b0;
            res_used_reg <= 1'b0;
            res_key_reg  <= '0;
            res_cnt_reg  <= '0;
        end
        if (match && !hit_reg)
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_cnt_reg <= rd_data_reg.count;
        end
        if (cmd.step == stmac_pkg::STEP_SCAN && !valid_reg[idx_reg] && !empty_reg)
        begin
            empty_idx_reg <= idx_reg;
        end
        if (cmd.step == stmac_pkg::STEP_SWAP_RDB)
        begin
            hold_reg <= rd_data_reg;
        end
        case (cmd.step)
            stmac_pkg::STEP_REMOVE, stmac_pkg::STEP_SWAP_WRA, stmac_pkg::STEP_CMP:
            begin
                res_ok_reg <= 1'b1;
            end
            stmac_pkg::STEP_ADD_WR:
            begin
                res_ok_reg <= hit_reg || empty_reg;
            end
            stmac_pkg::STEP_RD_DONE:
            begin
                res_ok_reg   <= 1'b1;
                res_used_reg <= valid_reg[a_idx];
                // an empty slot shows zeros, never the stale store
                res_key_reg  <= valid_reg[a_idx] ? rd_data_reg.key : '0;
                res_cnt_reg  <= valid_reg[a_idx] ? rd_data_reg.count : '0;
            end
            default:
            begin
                // hold
            end
        endcase
        if (cmd.step == stmac_pkg::STEP_RESP)
        begin
            ok_reg   <= res_ok_reg;
            used_reg <= res_used_reg;
            okey_reg <= res_key_reg;
            ocnt_reg <= res_cnt_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign slot_used       = used_reg;
    assign slot_item_key   = okey_reg;
    assign slot_item_count = ocnt_reg;

endmodule

[sv/stmac_chk.sv]
// ----------------------------------------------------------------------------
// stmac_chk
// Port-level checks for the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module stmac_chk
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           ok,
    input logic                           slot_used,
    input logic [stmac_pkg::KEY_W-1:0]    slot_item_key,
    input logic [stmac_pkg::CNT_W-1:0]    slot_item_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(slot_used)
        && $stable(slot_item_key) && $stable(slot_item_count))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in work");

    a_used_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_used |-> ok)
        else $error("slot_used without ok");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !slot_used |-> slot_item_key == '0 && slot_item_count == '0)
        else $error("slot fields not zero on empty or non-read result");

endmodule

bind slot_table_merge_alloc_compact stmac_chk u_stmac_chk
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ok              (ok),
    .slot_used       (slot_used),
    .slot_item_key   (slot_item_key),
    .slot_item_count (slot_item_count)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot table. A directed table of words runs
// first (reset state, field extremes, every op, merge, self-swap, range
// errors, reserved codes), then a fill to capacity and a long random run.
// Every result word is checked field by field against the directed row's typed
// result or else an in-bench table model, amid random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W   = stmac_pkg::OP_W;
    localparam int KEY_W  = stmac_pkg::KEY_W;
    localparam int AMT_W  = stmac_pkg::AMT_W;
    localparam int CNT_W  = stmac_pkg::CNT_W;
    localparam int SLOT_W = stmac_pkg::SLOT_W;

    typedef stmac_pkg::op_code_t op_code_t;

    localparam op_code_t OP_ADD     = stmac_pkg::OP_ADD;
    localparam op_code_t OP_REMOVE  = stmac_pkg::OP_REMOVE;
    localparam op_code_t OP_SWAP    = stmac_pkg::OP_SWAP;
    localparam op_code_t OP_COMPACT = stmac_pkg::OP_COMPACT;
    localparam op_code_t OP_READ    = stmac_pkg::OP_READ;

    localparam int TABLE_SLOTS   = stmac_pkg::SLOTS_DEF;
    localparam int SLOT_TOP      = (1 << SLOT_W) - 1;
    localparam int RANDOM_WORDS  = 335;
    localparam int FILL_WORDS    = TABLE_SLOTS + 8;
    localparam int DIR_ROWS      = 25;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 4 * (TABLE_SLOTS + 5);

    localparam logic [KEY_W-1:0] FILL_KEY_BASE = 16'h0100;
    localparam logic [KEY_W-1:0] POOL_KEY_BASE = 16'h5A00;

    localparam op_code_t OP_RSVD_A = 3'd5;
    localparam op_code_t OP_RSVD_B = 3'd6;
    localparam op_code_t OP_RSVD_C = 3'd7;

    typedef struct packed {
        logic             ok;
        logic             used;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } slot_result_t;

    typedef struct packed {
        op_code_t          op;
        logic [KEY_W-1:0]  key;
        logic [AMT_W-1:0]  amt;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
        logic              typed;
        slot_result_t      res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op = '0;
    logic [KEY_W-1:0]    item_key = '0;
    logic [AMT_W-1:0]    add_count = '0;
    logic [SLOT_W-1:0]   slot_a = '0;
    logic [SLOT_W-1:0]   slot_b = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                ok;
    logic                slot_used;
    logic [KEY_W-1:0]    slot_item_key;
    logic [CNT_W-1:0]    slot_item_count;

    // model copy of the table
    logic                slot_live  [TABLE_SLOTS];
    logic [KEY_W-1:0]    slot_key   [TABLE_SLOTS];
    logic [CNT_W-1:0]    slot_count [TABLE_SLOTS];

    slot_result_t        pending_results [$];
    stim_row_t           directed_rows [DIR_ROWS];
    logic                quiet = 1'b0;
    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  refused_words = 0;
    int                  words_by_op [8];
    slot_result_t        seen_res;
    slot_result_t        want_res;

    slot_table_merge_alloc_compact #(
        .SLOTS(TABLE_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .item_key(item_key),
        .add_count(add_count),
        .slot_a(slot_a),
        .slot_b(slot_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ok(ok),
        .slot_used(slot_used),
        .slot_item_key(slot_item_key),
        .slot_item_count(slot_item_count)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t, result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    function automatic void exchange_entries(input int x, input int y);
        logic             v;
        logic [KEY_W-1:0] k;
        logic [CNT_W-1:0] c;
        v = slot_live[x];
        k = slot_key[x];
        c = slot_count[x];
        slot_live[x]  = slot_live[y];
        slot_key[x]   = slot_key[y];
        slot_count[x] = slot_count[y];
        slot_live[y]  = v;
        slot_key[y]   = k;
        slot_count[y] = c;
    endfunction

    function automatic slot_result_t apply_table_op(input op_code_t o,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [AMT_W-1:0] n,
                                                    input logic [SLOT_W-1:0] sa,
                                                    input logic [SLOT_W-1:0] sb);
        slot_result_t   r;
        logic           done;
        logic [CNT_W:0] sum;
        int             w;
        r = '0;
        done = 1'b0;
        w = 0;
        case (o)
            OP_ADD:
            begin
                // merge first, then allocate the lowest empty slot
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (!done && slot_live[i] && slot_key[i] == k)
                    begin
                        sum = {1'b0, slot_count[i]} + n;
                        slot_count[i] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                        done = 1'b1;
                    end
                end
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (!done && !slot_live[i])
                    begin
                        slot_live[i]  = 1'b1;
                        slot_key[i]   = k;
                        slot_count[i] = CNT_W'(n);
                        done = 1'b1;
                    end
                end
                r.ok = done;
            end
            OP_REMOVE:
            begin
                if (sa < TABLE_SLOTS)
                begin
                    slot_live[sa] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_SWAP:
            begin
                if (sa < TABLE_SLOTS && sb < TABLE_SLOTS)
                begin
                    exchange_entries(sa, sb);
                    r.ok = 1'b1;
                end
            end
            OP_COMPACT:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (i != w)
                            exchange_entries(i, w);
                        w++;
                    end
                end
                r.ok = 1'b1;
            end
            OP_READ:
            begin
                if (sa < TABLE_SLOTS)
                begin
                    r.ok = 1'b1;
                    if (slot_live[sa])
                    begin
                        r.used  = 1'b1;
                        r.key   = slot_key[sa];
                        r.count = slot_count[sa];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one word at the falling edge, hold it until accepted
    task automatic send_word(input op_code_t o, input logic [KEY_W-1:0] k,
                             input logic [AMT_W-1:0] n, input logic [SLOT_W-1:0] sa,
                             input logic [SLOT_W-1:0] sb, input logic typed,
                             input slot_result_t typed_res);
        int           gap;
        slot_result_t model_res;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op        = o;
        item_key  = k;
        add_count = n;
        slot_a    = sa;
        slot_b    = sb;
        in_valid  = 1'b1;
        do @(posedge clk); while (!in_ready);
        model_res = apply_table_op(o, k, n, sa, sb);
        pending_results.push_back(typed ? typed_res : model_res);
        words_by_op[o]++;
        if (!model_res.ok)
            refused_words++;
        @(negedge clk);
    endtask

    // receiver: stall a random number of cycles per word
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_res = '{ok, slot_used, slot_item_key, slot_item_count};
            if (pending_results.size() == 0)
            begin
                flag_error("result word with nothing expected");
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (seen_res.ok !== want_res.ok)
                    flag_error($sformatf("ok got %0b want %0b", seen_res.ok, want_res.ok));
                if (seen_res.used !== want_res.used)
                    flag_error($sformatf("slot_used got %0b want %0b",
                                         seen_res.used, want_res.used));
                if (seen_res.key !== want_res.key)
                    flag_error($sformatf("slot_item_key got %h want %h",
                                         seen_res.key, want_res.key));
                if (seen_res.count !== want_res.count)
                    flag_error($sformatf("slot_item_count got %h want %h",
                                         seen_res.count, want_res.count));
            end
            results_seen++;
        end
    end

    initial
    begin
        #2ms;
        $display("watchdog expired at %0t with %0d results outstanding",
                 $time, pending_results.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                 guard;
        int                 pick;
        op_code_t           r_op;
        logic [KEY_W-1:0]   r_key;
        logic [AMT_W-1:0]   r_amt;
        logic [SLOT_W-1:0]  r_a;
        logic [SLOT_W-1:0]  r_b;

        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            words_by_op[i] = 0;

        //  op          key       amt       a    b    typed  ok used key  count
        directed_rows = '{
            '{OP_READ,    16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'hFFFF, 16'hFFFF, 8'd31,  8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd32,  8'd0,  1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd255, 8'd255, 1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_REMOVE,  16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_COMPACT, 16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_ADD,     16'hFFFF, 16'hFFFF, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_ADD,     16'h0000, 16'h0000, 8'd255, 8'd255, 1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd0,   8'd0,
              1'b1, '{1'b1, 1'b1, 16'hFFFF, 32'h0000FFFF}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd1,   8'd0,  1'b1, '{1'b1, 1'b1, 16'h0, 32'h0}},
            '{OP_ADD,     16'hFFFF, 16'h0001, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0, '0},
            '{OP_SWAP,    16'h0000, 16'h0000, 8'd0,   8'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_SWAP,    16'h0000, 16'h0000, 8'd1,   8'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_SWAP,    16'h0000, 16'h0000, 8'd0,   8'd32, 1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_SWAP,    16'h0000, 16'h0000, 8'd255, 8'd0,  1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_REMOVE,  16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_REMOVE,  16'h0000, 16'h0000, 8'd200, 8'd0,  1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd1,   8'd0,  1'b0, '0},
            '{OP_COMPACT, 16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, '{1'b1, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0, '0},
            '{OP_RSVD_A,  16'hFFFF, 16'hFFFF, 8'd0,   8'd0,  1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_RSVD_B,  16'h0000, 16'h0000, 8'd255, 8'd255, 1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_RSVD_C,  16'h1234, 16'h0001, 8'd1,   8'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 32'h0}},
            '{OP_READ,    16'h0000, 16'h0000, 8'd1,   8'd0,  1'b0, '0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].amt,
                      directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                      directed_rows[i].res);

        // fill to capacity; the last new keys must be refused
        for (int i = 0; i < FILL_WORDS; i++)
            send_word(OP_ADD, FILL_KEY_BASE + KEY_W'(i), AMT_W'($urandom),
                      SLOT_W'($urandom), SLOT_W'($urandom), 1'b0, '0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // switch between idling and back-to-back stretches
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r_op = OP_ADD;
            else if (pick < 55)
                r_op = OP_REMOVE;
            else if (pick < 70)
                r_op = OP_SWAP;
            else if (pick < 77)
                r_op = OP_COMPACT;
            else if (pick < 96)
                r_op = OP_READ;
            else
                r_op = op_code_t'($urandom_range(OP_RSVD_A, OP_RSVD_C));
            r_key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                                : POOL_KEY_BASE + KEY_W'($urandom_range(0, 39));
            pick = $urandom_range(0, 9);
            r_amt = (pick == 0) ? '0 : (pick == 1) ? '1 : AMT_W'($urandom);
            r_a = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(TABLE_SLOTS, SLOT_TOP))
                                              : SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
            r_b = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(TABLE_SLOTS, SLOT_TOP))
                                              : SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
            send_word(r_op, r_key, r_amt, r_a, r_b, 1'b0, '0);
        end
        quiet = 1'b0;
        in_valid = 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d result words never arrived", pending_results.size()));

        $display("%0d words: %0d add, %0d remove, %0d swap, %0d compact, %0d read, %0d reserved",
                 results_seen, words_by_op[OP_ADD], words_by_op[OP_REMOVE],
                 words_by_op[OP_SWAP], words_by_op[OP_COMPACT], words_by_op[OP_READ],
                 words_by_op[OP_RSVD_A] + words_by_op[OP_RSVD_B] + words_by_op[OP_RSVD_C]);
        $display("%0d refused, table filled to capacity with new keys turned away",
                 refused_words);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
